@@ src/crd_pkg.sv @@
// ----------------------------------------------------------------------------
// crd_pkg
// Shared codes and controller/datapath interface types of the coalescing
// request dispatcher.
// ----------------------------------------------------------------------------
package crd_pkg;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;

    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_DELIVER  = 2'd1;
    localparam logic [1:0] KIND_STORE    = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [4:0] U_IDLE     = 5'd0;
    localparam logic [4:0] U_START    = 5'd1;
    localparam logic [4:0] U_SCAN     = 5'd2;
    localparam logic [4:0] U_SEEK     = 5'd3;
    localparam logic [4:0] U_WD_INIT  = 5'd4;
    localparam logic [4:0] U_WD_RD    = 5'd5;
    localparam logic [4:0] U_WD_WR    = 5'd6;
    localparam logic [4:0] U_WD_END   = 5'd7;
    localparam logic [4:0] U_NQ_NEW   = 5'd8;
    localparam logic [4:0] U_NQ_JOIN  = 5'd9;
    localparam logic [4:0] U_OVF      = 5'd10;
    localparam logic [4:0] U_FN_INIT  = 5'd11;
    localparam logic [4:0] U_FN_RD    = 5'd12;
    localparam logic [4:0] U_FN_CHK   = 5'd13;
    localparam logic [4:0] U_FN_DLV   = 5'd14;
    localparam logic [4:0] U_FN_STORE = 5'd15;
    localparam logic [4:0] U_DP_INIT  = 5'd16;
    localparam logic [4:0] U_DP_MOD   = 5'd17;
    localparam logic [4:0] U_DP_FIND  = 5'd18;
    localparam logic [4:0] U_DP_POP   = 5'd19;
    localparam logic [4:0] U_DP_SEND  = 5'd20;
    localparam logic [4:0] U_FLUSH    = 5'd21;

    typedef struct packed {
        logic [4:0] uop;
    } t_cmd;

    typedef struct packed {
        logic is_req;
        logic is_fin;
        logic pend_v;
        logic scan_hit;
        logic scan_last;
        logic free_ok;
        logic cnt_full;
        logic loop_done;
        logic dl_hit;
        logic have_owner;
        logic can_emit;
        logic stg_vld;
        logic out_free;
        logic w_over;
        logic off_done;
        logic w_idle;
        logic fifo_empty;
        logic head_serve;
    } t_status;

endpackage

@@ src/crd_ctrl.sv @@
// ----------------------------------------------------------------------------
// crd_ctrl
// Sequencer of the dispatcher: walks each item through withdrawal, join,
// completion and dispatch steps and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module crd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_accept,
    input  crd_pkg::t_status i_status,
    output crd_pkg::t_cmd   o_cmd,
    output logic            o_in_ready
);
    import crd_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_START    = 5'd1;
    localparam logic [4:0] S_WD_SCAN  = 5'd2;
    localparam logic [4:0] S_SEEK     = 5'd3;
    localparam logic [4:0] S_WD_INIT  = 5'd4;
    localparam logic [4:0] S_WD_RD    = 5'd5;
    localparam logic [4:0] S_WD_WR    = 5'd6;
    localparam logic [4:0] S_WD_END   = 5'd7;
    localparam logic [4:0] S_NQ_SCAN  = 5'd8;
    localparam logic [4:0] S_NQ_NEW   = 5'd9;
    localparam logic [4:0] S_NQ_JOIN  = 5'd10;
    localparam logic [4:0] S_OVF      = 5'd11;
    localparam logic [4:0] S_FN_SCAN  = 5'd12;
    localparam logic [4:0] S_FN_INIT  = 5'd13;
    localparam logic [4:0] S_FN_RD    = 5'd14;
    localparam logic [4:0] S_FN_CHK   = 5'd15;
    localparam logic [4:0] S_FN_DLV   = 5'd16;
    localparam logic [4:0] S_FN_STORE = 5'd17;
    localparam logic [4:0] S_DP_INIT  = 5'd18;
    localparam logic [4:0] S_DP_MOD   = 5'd19;
    localparam logic [4:0] S_DP_FIND  = 5'd20;
    localparam logic [4:0] S_DP_POP   = 5'd21;
    localparam logic [4:0] S_DP_SEND  = 5'd22;
    localparam logic [4:0] S_FLUSH    = 5'd23;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd.uop = U_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_in_accept) n_state = S_START;
            end
            S_START: begin
                o_cmd.uop = U_START;
                if (i_status.is_req) begin
                    n_state = i_status.pend_v ? S_WD_SCAN : S_NQ_SCAN;
                end else if (i_status.is_fin) begin
                    n_state = S_FN_SCAN;
                end else begin
                    n_state = S_DP_INIT;
                end
            end
            S_WD_SCAN: begin
                o_cmd.uop = U_SCAN;
                if (i_status.scan_hit) n_state = S_WD_INIT;
                else if (i_status.scan_last) n_state = S_SEEK;
            end
            S_SEEK: begin
                o_cmd.uop = U_SEEK;
                n_state = S_NQ_SCAN;
            end
            S_WD_INIT: begin
                o_cmd.uop = U_WD_INIT;
                n_state = S_WD_RD;
            end
            S_WD_RD: begin
                o_cmd.uop = U_WD_RD;
                n_state = i_status.loop_done ? S_WD_END : S_WD_WR;
            end
            S_WD_WR: begin
                o_cmd.uop = U_WD_WR;
                n_state = S_WD_RD;
            end
            S_WD_END: begin
                o_cmd.uop = U_WD_END;
                n_state = S_SEEK;
            end
            S_NQ_SCAN: begin
                o_cmd.uop = U_SCAN;
                if (i_status.scan_hit) n_state = S_NQ_JOIN;
                else if (i_status.scan_last) n_state = S_NQ_NEW;
            end
            S_NQ_NEW: begin
                o_cmd.uop = U_NQ_NEW;
                n_state = i_status.free_ok ? S_NQ_JOIN : S_OVF;
            end
            S_NQ_JOIN: begin
                o_cmd.uop = U_NQ_JOIN;
                n_state = i_status.cnt_full ? S_OVF : S_DP_INIT;
            end
            S_OVF: begin
                o_cmd.uop = U_OVF;
                if (i_status.can_emit) n_state = S_DP_INIT;
            end
            S_FN_SCAN: begin
                o_cmd.uop = U_SCAN;
                if (i_status.scan_hit) n_state = S_FN_INIT;
                else if (i_status.scan_last) n_state = S_DP_INIT;
            end
            S_FN_INIT: begin
                o_cmd.uop = U_FN_INIT;
                n_state = S_FN_RD;
            end
            S_FN_RD: begin
                o_cmd.uop = U_FN_RD;
                n_state = i_status.loop_done ? S_FN_STORE : S_FN_CHK;
            end
            S_FN_CHK: begin
                o_cmd.uop = U_FN_CHK;
                n_state = i_status.dl_hit ? S_FN_DLV : S_FN_RD;
            end
            S_FN_DLV: begin
                o_cmd.uop = U_FN_DLV;
                if (i_status.can_emit) n_state = S_FN_RD;
            end
            S_FN_STORE: begin
                o_cmd.uop = U_FN_STORE;
                if (!i_status.have_owner || i_status.can_emit) n_state = S_DP_INIT;
            end
            S_DP_INIT: begin
                o_cmd.uop = U_DP_INIT;
                n_state = S_DP_MOD;
            end
            S_DP_MOD: begin
                o_cmd.uop = U_DP_MOD;
                if (!i_status.w_over) n_state = S_DP_FIND;
            end
            S_DP_FIND: begin
                o_cmd.uop = U_DP_FIND;
                if (i_status.off_done) n_state = S_FLUSH;
                else if (i_status.w_idle) n_state = S_DP_POP;
            end
            S_DP_POP: begin
                o_cmd.uop = U_DP_POP;
                if (i_status.fifo_empty) n_state = S_FLUSH;
                else if (i_status.head_serve) n_state = S_DP_SEND;
            end
            S_DP_SEND: begin
                o_cmd.uop = U_DP_SEND;
                if (i_status.can_emit) n_state = S_DP_INIT;
            end
            S_FLUSH: begin
                o_cmd.uop = U_FLUSH;
                if (!i_status.stg_vld || i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ src/crd_datapath.sv @@
// ----------------------------------------------------------------------------
// crd_datapath
// Entry table, waiter list memory, pending keys, order queue, worker pool and
// the staged result path of the dispatcher.
// ----------------------------------------------------------------------------
module crd_datapath #(
    parameter int REQUESTERS = 8,
    parameter int WORKERS    = 4,
    parameter int ENTRIES    = 16,
    parameter int TAG_BITS   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_accept,
    input  logic [1:0]       i_op,
    input  logic [31:0]      i_key,
    input  logic [2:0]       i_req,
    input  logic [1:0]       i_dwk,
    input  logic             i_failed,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_data,
    input  crd_pkg::t_cmd    i_cmd,
    output crd_pkg::t_status o_status,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_key,
    output logic [2:0]       o_req,
    output logic [1:0]       o_worker,
    output logic             o_error,
    output logic             o_last
);
    import crd_pkg::*;

    localparam int RW   = $clog2(REQUESTERS);
    localparam int CW   = $clog2(REQUESTERS + 1);
    localparam int EW   = $clog2(ENTRIES);
    localparam int QW   = $clog2(ENTRIES + 1);
    localparam int PW   = $clog2(WORKERS + 1);
    localparam int WIDX = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int WLD  = ENTRIES * (2 ** RW);

    logic [1:0]          r_op;
    logic [TAG_BITS-1:0] r_key;
    logic [RW-1:0]       r_req;
    logic                r_req_bad;
    logic [1:0]          r_dwk;
    logic                r_failed;
    logic [2:0]          r_cfg;

    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_active;
    logic [ENTRIES-1:0]  r_queued;
    logic [CW-1:0]       r_count [ENTRIES];
    logic [TAG_BITS-1:0] r_tag [ENTRIES];

    logic [RW-1:0]       r_wl [WLD];
    logic [RW-1:0]       r_wl_q;

    logic [REQUESTERS-1:0] r_pv;
    logic [TAG_BITS-1:0]   r_ptag [REQUESTERS];

    logic [EW-1:0]       r_fifo [ENTRIES];
    logic [QW-1:0]       r_qcnt;

    logic [WORKERS-1:0]  r_busy;
    logic [WIDX-1:0]     r_ptr;
    logic [WIDX-1:0]     r_w;
    logic [PW-1:0]       r_off;

    logic [TAG_BITS-1:0] r_skey;
    logic [EW-1:0]       r_idx;
    logic [EW-1:0]       r_ecur;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_k;
    logic [CW-1:0]       r_cnt;
    logic [RW-1:0]       r_who;
    logic [RW-1:0]       r_owner;
    logic                r_have;

    logic                r_sv;
    logic [1:0]          r_s_kind;
    logic [31:0]         r_s_key;
    logic [2:0]          r_s_req;
    logic [1:0]          r_s_wk;
    logic                r_s_err;

    logic                r_ov;
    logic [1:0]          r_o_kind;
    logic [31:0]         r_o_key;
    logic [2:0]          r_o_req;
    logic [1:0]          r_o_wk;
    logic                r_o_err;
    logic                r_o_last;

    logic [PW-1:0]       w_np;
    logic [EW-1:0]       w_free;
    logic                w_free_ok;
    logic [EW-1:0]       w_rm_fifo [ENTRIES];
    logic [QW-1:0]       w_rm_cnt;
    logic                w_rm_seen;
    logic [EW-1:0]       w_head;
    logic [WIDX-1:0]     w_next;
    logic [RW-1:0]       w_pa;
    logic                w_wl_we;
    logic [EW+RW-1:0]    w_wl_wa;
    logic                w_wl_re;
    logic                w_emit;
    logic [1:0]          w_e_kind;
    logic [31:0]         w_e_key;
    logic [2:0]          w_e_req;
    logic [1:0]          w_e_wk;
    logic                w_out_free;
    logic                w_can_emit;
    logic                w_flush;
    logic                w_keep;
    logic                w_dl_hit;
    logic                w_serve;

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_op      <= i_op;
            r_key     <= TAG_BITS'(i_key);
            r_req     <= RW'(i_req);
            r_req_bad <= (32'(i_req) >= 32'(REQUESTERS));
            r_dwk     <= i_dwk;
            r_failed  <= i_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 3'd4;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_cfg == 3'd0) begin
            w_np = PW'(1);
        end else if (32'(r_cfg) > 32'(WORKERS)) begin
            w_np = PW'(WORKERS);
        end else begin
            w_np = PW'(r_cfg);
        end
    end

    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                w_free_ok = 1'b1;
                w_free    = EW'(j);
            end
        end
    end

    always_comb begin
        w_rm_seen = 1'b0;
        for (int j = 0; j < ENTRIES; j++) begin
            if ((32'(j) < 32'(r_qcnt)) && (r_fifo[j] == r_ecur)) w_rm_seen = 1'b1;
            if (w_rm_seen && (j < ENTRIES - 1)) begin
                w_rm_fifo[j] = r_fifo[(j < ENTRIES - 1) ? j + 1 : j];
            end else begin
                w_rm_fifo[j] = r_fifo[j];
            end
        end
        w_rm_cnt = w_rm_seen ? r_qcnt - QW'(1) : r_qcnt;
    end

    assign w_head  = r_fifo[0];
    assign w_serve = r_valid[w_head] && !r_active[w_head] && (r_count[w_head] != '0);
    assign w_next  = ((PW'(r_w) + PW'(1)) == w_np) ? '0 : r_w + WIDX'(1);
    assign w_pa    = (i_cmd.uop == U_FN_CHK) ? r_wl_q : r_req;
    assign w_keep  = (r_wl_q != r_req);
    assign w_dl_hit = r_pv[w_pa] && (r_ptag[w_pa] == r_skey);

    always_comb begin
        w_wl_we = 1'b0;
        w_wl_wa = {r_ecur, r_k[RW-1:0]};
        if (i_cmd.uop == U_WD_WR) begin
            w_wl_we = w_keep;
        end else if (i_cmd.uop == U_NQ_JOIN) begin
            w_wl_we = (r_count[r_ecur] < CW'(REQUESTERS));
            w_wl_wa = {r_ecur, r_count[r_ecur][RW-1:0]};
        end
    end

    assign w_wl_re = (i_cmd.uop == U_WD_RD) || (i_cmd.uop == U_FN_RD);

    always_ff @(posedge i_clk) begin
        if (w_wl_we) begin
            r_wl[w_wl_wa] <= (i_cmd.uop == U_WD_WR) ? r_wl_q : r_req;
        end
        if (w_wl_re) begin
            r_wl_q <= r_wl[{r_ecur, r_i[RW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
            r_queued <= '0;
            r_pv     <= '0;
            r_qcnt   <= '0;
            r_busy   <= '0;
            r_ptr    <= '0;
            for (int j = 0; j < ENTRIES; j++) r_count[j] <= '0;
        end else begin
            case (i_cmd.uop)
                U_START: begin
                    r_idx <= '0;
                    if ((r_op == OP_REQUEST) && !r_req_bad) begin
                        if (r_pv[r_req]) begin
                            r_pv[r_req] <= 1'b0;
                            r_skey      <= r_ptag[r_req];
                        end else begin
                            r_skey <= r_key;
                        end
                    end else if (r_op == OP_FINISH) begin
                        r_skey <= r_key;
                        if (PW'(r_dwk) < w_np && 32'(r_dwk) < 32'(w_np)) begin
                            r_busy[WIDX'(r_dwk)] <= 1'b0;
                        end
                    end
                end
                U_SCAN: begin
                    if (r_valid[r_idx] && (r_tag[r_idx] == r_skey)) r_ecur <= r_idx;
                    r_idx <= r_idx + EW'(1);
                end
                U_SEEK: begin
                    r_skey <= r_key;
                    r_idx  <= '0;
                end
                U_WD_INIT: begin
                    r_i   <= '0;
                    r_k   <= '0;
                    r_cnt <= r_count[r_ecur];
                end
                U_WD_WR: begin
                    if (w_keep) r_k <= r_k + CW'(1);
                    r_i <= r_i + CW'(1);
                end
                U_WD_END: begin
                    r_count[r_ecur] <= r_k;
                    if ((r_k == '0) && !r_active[r_ecur]) begin
                        r_valid[r_ecur]  <= 1'b0;
                        r_queued[r_ecur] <= 1'b0;
                        r_fifo           <= w_rm_fifo;
                        r_qcnt           <= w_rm_cnt;
                    end
                end
                U_NQ_NEW: begin
                    if (w_free_ok) begin
                        r_ecur           <= w_free;
                        r_valid[w_free]  <= 1'b1;
                        r_tag[w_free]    <= r_skey;
                        r_active[w_free] <= 1'b0;
                        r_queued[w_free] <= 1'b0;
                        r_count[w_free]  <= '0;
                    end
                end
                U_NQ_JOIN: begin
                    if (r_count[r_ecur] < CW'(REQUESTERS)) begin
                        r_count[r_ecur] <= r_count[r_ecur] + CW'(1);
                        r_pv[r_req]     <= 1'b1;
                        r_ptag[r_req]   <= r_key;
                        if (!r_queued[r_ecur] && !r_active[r_ecur]
                                && (r_qcnt < QW'(ENTRIES))) begin
                            r_queued[r_ecur]         <= 1'b1;
                            r_fifo[r_qcnt[EW-1:0]]   <= r_ecur;
                            r_qcnt                   <= r_qcnt + QW'(1);
                        end
                    end
                end
                U_FN_INIT: begin
                    r_cnt            <= r_count[r_ecur];
                    r_i              <= '0;
                    r_have           <= 1'b0;
                    r_valid[r_ecur]  <= 1'b0;
                    r_active[r_ecur] <= 1'b0;
                    r_queued[r_ecur] <= 1'b0;
                    r_count[r_ecur]  <= '0;
                    r_fifo           <= w_rm_fifo;
                    r_qcnt           <= w_rm_cnt;
                end
                U_FN_CHK: begin
                    r_who <= r_wl_q;
                    if (!w_dl_hit) r_i <= r_i + CW'(1);
                end
                U_FN_DLV: begin
                    if (w_can_emit) begin
                        r_pv[r_who] <= 1'b0;
                        if (!r_have) begin
                            r_have  <= 1'b1;
                            r_owner <= r_who;
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                U_DP_INIT: begin
                    r_w   <= r_ptr;
                    r_off <= '0;
                end
                U_DP_MOD: begin
                    if (PW'(r_w) >= w_np) r_w <= WIDX'(PW'(r_w) - w_np);
                end
                U_DP_FIND: begin
                    if (r_off < w_np) begin
                        if (!r_busy[r_w]) begin
                            r_ptr <= w_next;
                        end else begin
                            r_w   <= w_next;
                            r_off <= r_off + PW'(1);
                        end
                    end
                end
                U_DP_POP: begin
                    if (r_qcnt != '0) begin
                        for (int j = 0; j < ENTRIES - 1; j++) r_fifo[j] <= r_fifo[j + 1];
                        r_qcnt <= r_qcnt - QW'(1);
                        if (r_valid[w_head]) r_queued[w_head] <= 1'b0;
                        if (w_serve) r_ecur <= w_head;
                    end
                end
                U_DP_SEND: begin
                    if (w_can_emit) begin
                        r_active[r_ecur] <= 1'b1;
                        r_busy[r_w]      <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_ov || i_ready;
    assign w_can_emit = !r_sv || w_out_free;

    always_comb begin
        w_emit   = 1'b0;
        w_e_kind = KIND_DISPATCH;
        w_e_key  = 32'(r_key);
        w_e_req  = 3'd0;
        w_e_wk   = 2'd0;
        case (i_cmd.uop)
            U_OVF: begin
                w_emit   = 1'b1;
                w_e_kind = KIND_OVERFLOW;
                w_e_req  = 3'(r_req);
            end
            U_FN_DLV: begin
                w_emit   = 1'b1;
                w_e_kind = KIND_DELIVER;
                w_e_req  = 3'(r_who);
            end
            U_FN_STORE: begin
                w_emit   = r_have;
                w_e_kind = KIND_STORE;
                w_e_req  = 3'(r_owner);
            end
            U_DP_SEND: begin
                w_emit   = 1'b1;
                w_e_kind = KIND_DISPATCH;
                w_e_key  = 32'(r_tag[r_ecur]);
                w_e_wk   = 2'(r_w);
            end
            default: begin
            end
        endcase
    end

    assign w_flush = (i_cmd.uop == U_FLUSH) && r_sv && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (w_emit && w_can_emit) begin
                if (r_sv) begin
                    r_ov     <= 1'b1;
                    r_o_kind <= r_s_kind;
                    r_o_key  <= r_s_key;
                    r_o_req  <= r_s_req;
                    r_o_wk   <= r_s_wk;
                    r_o_err  <= r_s_err;
                    r_o_last <= 1'b0;
                end else if (i_ready) begin
                    r_ov <= 1'b0;
                end
                r_sv     <= 1'b1;
                r_s_kind <= w_e_kind;
                r_s_key  <= w_e_key;
                r_s_req  <= w_e_req;
                r_s_wk   <= w_e_wk;
                r_s_err  <= (w_e_kind == KIND_DELIVER || w_e_kind == KIND_STORE)
                            ? r_failed : 1'b0;
            end else if (w_flush) begin
                r_ov     <= 1'b1;
                r_o_kind <= r_s_kind;
                r_o_key  <= r_s_key;
                r_o_req  <= r_s_req;
                r_o_wk   <= r_s_wk;
                r_o_err  <= r_s_err;
                r_o_last <= 1'b1;
                r_sv     <= 1'b0;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid  = r_ov;
    assign o_kind   = r_o_kind;
    assign o_key    = r_o_key;
    assign o_req    = r_o_req;
    assign o_worker = r_o_wk;
    assign o_error  = r_o_err;
    assign o_last   = r_o_last;

    assign o_status.is_req     = (r_op == OP_REQUEST) && !r_req_bad;
    assign o_status.is_fin     = (r_op == OP_FINISH);
    assign o_status.pend_v     = r_pv[r_req];
    assign o_status.scan_hit   = r_valid[r_idx] && (r_tag[r_idx] == r_skey);
    assign o_status.scan_last  = (r_idx == EW'(ENTRIES - 1));
    assign o_status.free_ok    = w_free_ok;
    assign o_status.cnt_full   = (r_count[r_ecur] >= CW'(REQUESTERS));
    assign o_status.loop_done  = (r_i >= r_cnt);
    assign o_status.dl_hit     = w_dl_hit;
    assign o_status.have_owner = r_have;
    assign o_status.can_emit   = w_can_emit;
    assign o_status.stg_vld    = r_sv;
    assign o_status.out_free   = w_out_free;
    assign o_status.w_over     = (PW'(r_w) >= w_np);
    assign o_status.off_done   = (r_off >= w_np);
    assign o_status.w_idle     = !r_busy[r_w];
    assign o_status.fifo_empty = (r_qcnt == '0);
    assign o_status.head_serve = w_serve;

endmodule

@@ src/coalescing_request_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// coalescing_request_dispatcher_top
// Miss-request coalescer with a round-robin worker pool.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel (tuser is the operation) and results leave
// on the m_axis channel (tuser is the result kind, tlast marks the final result
// of an item). The pool size is written on the cfg channel, which is always
// ready. The user must write it only while the block is idle; the block
// itself does not enforce this. One item is processed at a time. Each key
// lookup scans the entry table one entry per cycle, a withdrawal reads each
// old waiter and rewrites the ones it keeps, and a completion reads and
// checks each waiter and delivers to each waiter with a matching pending
// key. Each dispatch round steps past each busy worker it meets and pops
// each queue entry it takes.
// A finished result is held in a staging register and an output register, so
// the next item is accepted while the last result still waits on the
// receiver. A stalled receiver holds the block at its next result.
// Reset clears all valid bits, counts, the worker pool and the pointer, and
// sets the pool size to 4. No clearing pass is needed.
// ----------------------------------------------------------------------------
module coalescing_request_dispatcher_top #(
    parameter int REQUESTERS = 8,
    parameter int WORKERS    = 4,
    parameter int ENTRIES    = 16,
    parameter int TAG_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // item_key, requester, done_worker, failed
    input  logic [1:0]  i_s_axis_tuser,   // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // out_key, out_requester, out_worker, out_error
    output logic [1:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    import crd_pkg::*;

    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_accept;
    logic [31:0] w_key;
    logic [2:0]  w_req;
    logic [1:0]  w_wk;
    logic        w_err;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    crd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_accept),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_s_axis_tready)
    );

    crd_datapath #(
        .REQUESTERS (REQUESTERS),
        .WORKERS    (WORKERS),
        .ENTRIES    (ENTRIES),
        .TAG_BITS   (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_accept),
        .i_op        (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[31:0]),
        .i_req       (i_s_axis_tdata[34:32]),
        .i_dwk       (i_s_axis_tdata[36:35]),
        .i_failed    (i_s_axis_tdata[37]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_kind      (o_m_axis_tuser),
        .o_key       (w_key),
        .o_req       (w_req),
        .o_worker    (w_wk),
        .o_error     (w_err),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_err, w_wk, w_req, w_key};

endmodule
